// File: rtl/core/lir_pkg.sv
// shared types, constants and sample decode for the linear interpolation resampler
`timescale 1ns / 1ps
`default_nettype none

package lir_pkg;

  // phase is unsigned 5.16: five integer bits, sixteen fraction bits
  localparam int PHASE_W     = 21;
  localparam int FRAC_W      = 16;
  localparam int SAMPLE_W    = 16;
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS);

  localparam logic [PHASE_W-1:0] ONE_FRAME = PHASE_W'(32'h0001_0000);
  localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(MAX_RESULTS - 1);

  // sample format codes
  localparam logic [1:0] FMT_LE16 = 2'd0;
  localparam logic [1:0] FMT_BE16 = 2'd1;
  localparam logic [1:0] FMT_S8   = 2'd2;
  localparam logic [1:0] FMT_U8   = 2'd3;

  // register indexes
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_STEREO = 2'd1;
  localparam logic [1:0] REG_STEP   = 2'd2;

  typedef struct packed {
    logic [15:0] left_word;
    logic [15:0] right_word;
    logic        final_frame;
  } frame_t;

  typedef struct packed {
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
    logic               run_end;
  } sample_t;

  typedef struct packed {
    logic [1:0]         sample_format;
    logic               stereo_source;
    logic [PHASE_W-1:0] step_rate;
  } cfg_t;

  // raw word to signed 16-bit sample
  function automatic logic signed [15:0] decode_word(input logic [1:0] fmt,
                                                     input logic [15:0] w);
    logic [15:0] r;
    unique case (fmt)
      FMT_LE16: r = w;
      FMT_BE16: r = {w[7:0], w[15:8]};
      FMT_S8:   r = {w[7:0], 8'h00};
      FMT_U8:   r = {~w[7], w[6:0], 8'h00};
      default:  r = w;
    endcase
    return $signed(r);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/lir_regs.sv
// configuration registers behind the apb port
`timescale 1ns / 1ps
`default_nettype none

module lir_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lir_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output lir_pkg::cfg_t                   cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_format <= lir_pkg::FMT_LE16;
      cfg.stereo_source <= 1'b1;
      cfg.step_rate     <= lir_pkg::ONE_FRAME;
    end else if (wr_en) begin
      unique case (reg_idx)
        lir_pkg::REG_FORMAT: cfg.sample_format <= pwdata[1:0];
        lir_pkg::REG_STEREO: cfg.stereo_source <= pwdata[0];
        lir_pkg::REG_STEP:   cfg.step_rate     <= pwdata[lir_pkg::PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      lir_pkg::REG_FORMAT: prdata = {30'd0, cfg.sample_format};
      lir_pkg::REG_STEREO: prdata = {31'd0, cfg.stereo_source};
      lir_pkg::REG_STEP:   prdata = {{(32 - lir_pkg::PHASE_W){1'b0}}, cfg.step_rate};
      default:             prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/lir_blend.sv
// shared blend unit: x0 + trunc((x1 - x0) * frac / 65536), product registered
`timescale 1ns / 1ps
`default_nettype none

module lir_blend (
  input  wire logic                              clk,
  input  wire logic                              go,
  input  wire logic signed [15:0]                x0,
  input  wire logic signed [15:0]                x1,
  input  wire logic        [lir_pkg::FRAC_W-1:0] frac,
  output logic signed      [15:0]                res
);

  logic signed [16:0] diff;
  logic signed [33:0] prod_next;
  logic signed [33:0] prod;
  logic signed [15:0] x0_q;
  logic signed [33:0] prod_adj;
  logic signed [33:0] quot;

  // difference and multiply
  assign diff      = 17'(x1) - 17'(x0);
  assign prod_next = 34'(diff) * 34'($signed({1'b0, frac}));

  // product stage, held until the next issue
  always_ff @(posedge clk) begin
    if (go) begin
      prod <= prod_next;
      x0_q <= x0;
    end
  end

  // round toward zero, then add the base sample
  assign prod_adj = prod + (prod[33] ? 34'sd65535 : 34'sd0);
  assign quot     = prod_adj >>> lir_pkg::FRAC_W;
  assign res      = x0_q + quot[15:0];

endmodule

`default_nettype wire

// File: rtl/core/lir_seq.sv
// sequencer: frame decode, phase tracking and output register
`timescale 1ns / 1ps
`default_nettype none

module lir_seq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire lir_pkg::cfg_t   cfg,
  input  wire logic            frame_valid,
  output logic                 frame_stall,
  input  wire lir_pkg::frame_t frame,
  output logic                 sample_valid,
  input  wire logic            sample_stall,
  output lir_pkg::sample_t     sample
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ML   = 3'd1;
  localparam logic [2:0] S_MR   = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;
  localparam logic [2:0] S_HOLD = 3'd4;

  localparam int PW = lir_pkg::PHASE_W;

  logic [2:0]                state;
  logic signed [15:0]        held_l, held_r, cur_l, cur_r, res_l;
  logic                      held_valid;
  logic                      last;
  logic [PW-1:0]             phase;
  logic [lir_pkg::CNT_W-1:0] cnt;

  logic signed [15:0] dec_l, dec_r;
  logic               accept, out_free, emit;
  logic               phase_lt, adv_lt, sub_lt, room;
  logic [PW:0]        phase_sum;
  logic [PW-1:0]      phase_adv, adv_sub, phase_drop;
  logic               blend_go;
  logic signed [15:0] blend_x0, blend_x1, blend_res;

  // decode incoming words
  assign dec_l = lir_pkg::decode_word(cfg.sample_format, frame.left_word);
  assign dec_r = cfg.stereo_source ? lir_pkg::decode_word(cfg.sample_format, frame.right_word)
                                   : dec_l;

  assign frame_stall = (state != S_IDLE);
  assign accept      = frame_valid && !frame_stall;
  assign out_free    = !sample_valid || !sample_stall;
  assign emit        = ((state == S_OUT) || (state == S_HOLD)) && out_free;

  // phase arithmetic: saturating advance, one-frame drop
  assign phase_sum  = {1'b0, phase} + {1'b0, cfg.step_rate};
  assign phase_adv  = phase_sum[PW] ? '1 : phase_sum[PW-1:0];
  assign adv_sub    = phase_adv - lir_pkg::ONE_FRAME;
  assign phase_drop = phase - lir_pkg::ONE_FRAME;
  assign phase_lt   = (phase[PW-1:lir_pkg::FRAC_W] == '0);
  assign adv_lt     = (phase_adv[PW-1:lir_pkg::FRAC_W] == '0);
  assign sub_lt     = (adv_sub[PW-1:lir_pkg::FRAC_W] == '0);
  assign room       = (cnt != lir_pkg::CNT_LAST);

  // shared blend unit, left then right
  assign blend_go = (state == S_ML) || (state == S_MR);
  assign blend_x0 = (state == S_ML) ? held_l : held_r;
  assign blend_x1 = (state == S_ML) ? cur_l : cur_r;

  lir_blend u_blend (
    .clk  (clk),
    .go   (blend_go),
    .x0   (blend_x0),
    .x1   (blend_x1),
    .frac (phase[lir_pkg::FRAC_W-1:0]),
    .res  (blend_res)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      held_valid   <= 1'b0;
      phase        <= '0;
      cnt          <= '0;
      last         <= 1'b0;
      sample_valid <= 1'b0;
    end else begin
      // output valid: set on a new sample, cleared once transferred
      sample_valid <= emit || (sample_valid && sample_stall);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cnt  <= '0;
            last <= frame.final_frame;
            if (held_valid && phase_lt) begin
              cur_l <= dec_l;
              cur_r <= dec_r;
              state <= S_ML;
            end else begin
              // first frame or skipped frame: just hold it
              held_l     <= dec_l;
              held_r     <= dec_r;
              held_valid <= 1'b1;
              if (!frame.final_frame) begin
                phase <= phase_lt ? phase : phase_drop;
              end else if (phase_lt) begin
                state <= S_HOLD;
              end else if (phase_drop[PW-1:lir_pkg::FRAC_W] == '0) begin
                phase <= phase_drop;
                state <= S_HOLD;
              end else begin
                held_valid <= 1'b0;
                phase      <= '0;
              end
            end
          end
        end
        S_ML: begin
          state <= S_MR;
        end
        S_MR: begin
          res_l <= blend_res;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            sample.out_left  <= res_l;
            sample.out_right <= blend_res;
            sample.run_end   <= !(room && (adv_lt || (last && sub_lt)));
            cnt              <= cnt + 1'b1;
            if (adv_lt && room) begin
              phase <= phase_adv;
              state <= S_ML;
            end else begin
              held_l <= cur_l;
              held_r <= cur_r;
              if (!last) begin
                phase <= adv_lt ? phase_adv : adv_sub;
                state <= S_IDLE;
              end else if (room && !adv_lt && sub_lt) begin
                phase <= adv_sub;
                state <= S_HOLD;
              end else begin
                held_valid <= 1'b0;
                phase      <= '0;
                state      <= S_IDLE;
              end
            end
          end
        end
        S_HOLD: begin
          if (out_free) begin
            sample.out_left  <= held_l;
            sample.out_right <= held_r;
            sample.run_end   <= !(adv_lt && room);
            cnt              <= cnt + 1'b1;
            if (adv_lt && room) begin
              phase <= phase_adv;
            end else begin
              held_valid <= 1'b0;
              phase      <= '0;
              state      <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (accept && held_valid && phase_lt) |=> (state == S_ML))
    else $error("interpolating frame accepted but blend sequence not started");

  a_hold_phase_in_frame: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD) |-> phase_lt)
    else $error("hold output with phase beyond one frame");

  a_no_phase_without_frame: assert property (@(posedge clk) disable iff (rst)
    !held_valid |-> (phase == '0))
    else $error("phase nonzero with no frame held");

  a_interp_needs_frame: assert property (@(posedge clk) disable iff (rst)
    (state == S_ML || state == S_MR || state == S_OUT) |-> held_valid)
    else $error("interpolating without a held frame");

endmodule

`default_nettype wire

// File: rtl/core/linear_interp_resampler.sv
// top level of the linear interpolation resampler
//
// Source frames come in on frame/frame_valid/frame_stall; output samples
// leave on sample/sample_valid/sample_stall. A transfer happens at a clock
// edge with valid high and stall low. Registers sit on an apb port: sample
// format at 0x0, stereo flag at 0x4, 5.16 step rate at 0x8.
// One frame is worked at a time; frame_stall is high from the cycle after a
// transfer until the frame's last output sample is in the output register.
// A frame that only gets stored (first frame, skipped frame) leaves
// frame_stall low. For each interpolated sample the one shared multiplier
// blends left, then right, then the result is loaded. Hold samples after a
// final frame repeat the held frame. Up to 64 samples per frame.
// When the receiver stalls, the output register holds its sample and the
// sequencer waits; frames are stalled meanwhile.
// Synchronous reset clears the held frame, the phase and the output valid,
// and loads the register defaults (16-bit little endian, stereo, step 1.0).
`timescale 1ns / 1ps
`default_nettype none

module linear_interp_resampler (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       frame_valid,
  output logic                            frame_stall,
  input  wire lir_pkg::frame_t            frame,
  output logic                            sample_valid,
  input  wire logic                       sample_stall,
  output lir_pkg::sample_t                sample,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lir_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);

  lir_pkg::cfg_t cfg;

  // configuration registers
  lir_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // datapath and sequencer
  lir_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame        (frame),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample)
  );

endmodule

`default_nettype wire
